### design/gfc_pkg.sv
// Package for the gated frequency counter display unit.
// Holds field widths, display codes and shared types; no dependencies.
package gfc_pkg;

  localparam int EDGE_W    = 24;
  localparam int TOTAL_W   = 32;
  localparam int GATE_W    = 8;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 4;
  localparam int QUO_W     = 24;  // total / 488 always fits in 24 bits
  localparam int CNT_W     = 4;   // counts up to eight display digits

  localparam int GATE_DIVISOR = 61 * 8;
  localparam logic [GATE_W-1:0] GATE_TICKS_RESET = 8'd32;

  localparam logic [DATA_W-1:0] CODE_E     = 4'hB;
  localparam logic [DATA_W-1:0] CODE_H     = 4'hC;
  localparam logic [DATA_W-1:0] CODE_L     = 4'hD;
  localparam logic [DATA_W-1:0] CODE_P     = 4'hE;
  localparam logic [DATA_W-1:0] CODE_BLANK = 4'hF;
  localparam logic [DATA_W-1:0] CODE_ZERO  = 4'h0;

  typedef struct packed {
    logic               done;
    logic [TOTAL_W-1:0] total;
  } gate_t;

  // Overflow message, one letter per step, leftmost register first.
  function automatic logic [DATA_W-1:0] help_code(input logic [1:0] idx);
    logic [DATA_W-1:0] code;
    case (idx)
      2'd0: code = CODE_H;
      2'd1: code = CODE_E;
      2'd2: code = CODE_L;
      2'd3: code = CODE_P;
      default: code = CODE_BLANK;
    endcase
    return code;
  endfunction

endpackage

### design/gfc_in_if.sv
// Input channel: one timebase tick with its edge count.
// Depends on gfc_pkg for the field width.
interface gfc_in_if import gfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EDGE_W-1:0] edge_count;

  modport source(output valid, output edge_count, input ready);
  modport sink(input valid, input edge_count, output ready);
endinterface

### design/gfc_out_if.sv
// Output channel: one digit-register write of a display update.
// Depends on gfc_pkg for the field widths.
interface gfc_out_if import gfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] reg_addr;
  logic [DATA_W-1:0] reg_data;
  logic              last;

  modport source(output valid, output reg_addr, output reg_data, output last, input ready);
  modport sink(input valid, input reg_addr, input reg_data, input last, output ready);
endinterface

### design/gfc_accum.sv
// Gate accumulator: saturating edge total, tick counter and gate length register.
// Depends on gfc_pkg.
module gfc_accum import gfc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [EDGE_W-1:0] edge_count,
  input  logic              cfg_we,
  input  logic [GATE_W-1:0] cfg_wdata,
  output gate_t             gate
);

  logic [TOTAL_W-1:0] edge_total;
  logic [GATE_W-1:0]  tick_index;
  logic [GATE_W-1:0]  gate_ticks;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_next;
  logic [GATE_W-1:0]  tick_next;
  logic               complete;

  always_comb begin
    sum        = {1'b0, edge_total} + (TOTAL_W + 1)'(edge_count);
    total_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    tick_next  = tick_index + 1'b1;
    complete   = !(tick_next < gate_ticks);
    gate.done  = fire && complete;
    gate.total = total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total <= '0;
      tick_index <= '0;
      gate_ticks <= GATE_TICKS_RESET;
    end else begin
      if (cfg_we) begin
        gate_ticks <= cfg_wdata;
      end
      if (fire) begin
        if (complete) begin
          edge_total <= '0;
          tick_index <= '0;
        end else begin
          edge_total <= total_next;
          tick_index <= tick_next;
        end
      end
    end
  end

endmodule

### design/gfc_sdiv.sv
// Bit-serial restoring divider by a constant: one quotient bit per cycle.
// Depends on gfc_pkg only through the shared import convention.
module gfc_sdiv import gfc_pkg::*; #(
  parameter int DIVIDEND_W = 32,
  parameter int DIVISOR    = 488
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [DIVIDEND_W-1:0]        dividend,
  output logic                         done,
  output logic [DIVIDEND_W-1:0]        quotient,
  output logic [$clog2(DIVISOR)-1:0]   remainder
);

  localparam int REM_W  = $clog2(DIVISOR);
  localparam int STEP_W = $clog2(DIVIDEND_W);
  localparam logic [REM_W:0]    DIV_C     = (REM_W + 1)'(DIVISOR);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [DIVIDEND_W-1:0] quo;
  logic [REM_W-1:0]      rem;
  logic [REM_W:0]        trial;
  logic                  fits;
  logic [REM_W-1:0]      rem_next;
  logic [DIVIDEND_W-1:0] quo_next;

  always_comb begin
    trial    = {rem, quo[DIVIDEND_W-1]};
    fits     = trial >= DIV_C;
    rem_next = fits ? REM_W'(trial - DIV_C) : trial[REM_W-1:0];
    quo_next = {quo[DIVIDEND_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out of the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### design/gfc_disp.sv
// Display write sequencer: blanks the digits, then writes zero, the overflow
// message or the decimal digits. Depends on gfc_pkg and gfc_sdiv.
module gfc_disp import gfc_pkg::*; #(
  parameter int NUM_DIGITS = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             gate_done,
  input  logic             quo_done,
  input  logic [QUO_W-1:0] quo,
  output logic             idle,
  gfc_out_if.source        disp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_W488  = 3'd1;
  localparam logic [2:0] S_BLANK = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_ZERO  = 3'd4;
  localparam logic [2:0] S_HELP  = 3'd5;
  localparam logic [2:0] S_W10   = 3'd6;
  localparam logic [2:0] S_DIGIT = 3'd7;

  localparam logic [31:0]       LIMIT     = 32'(10 ** NUM_DIGITS - 1);
  localparam logic [CNT_W-1:0]  NUM_CNT   = CNT_W'(NUM_DIGITS);
  localparam logic [ADDR_W-1:0] LSD_ADDR  = ADDR_W'(NUM_DIGITS);
  localparam logic [ADDR_W-1:0] HELP_BASE = ADDR_W'(NUM_DIGITS - 3);

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [QUO_W-1:0]  value;
  logic [CNT_W-1:0]  cnt;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] digit;
  logic              out_valid;
  logic [ADDR_W-1:0] out_addr;
  logic [DATA_W-1:0] out_data;
  logic              out_last;
  logic              out_load;
  logic              emit;
  logic [ADDR_W-1:0] emit_addr;
  logic [DATA_W-1:0] emit_data;
  logic              emit_last;
  logic              d10_start;
  logic              d10_done;
  logic [QUO_W-1:0]  d10_quo;
  logic [3:0]        d10_rem;

  gfc_sdiv #(
    .DIVIDEND_W(QUO_W),
    .DIVISOR   (10)
  ) u_div10 (
    .clk      (clk),
    .rst      (rst),
    .start    (d10_start),
    .dividend (value),
    .done     (d10_done),
    .quotient (d10_quo),
    .remainder(d10_rem)
  );

  // The output register is free when empty or when its transaction completes.
  assign out_load = !out_valid || disp.ready;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_addr  = cnt[ADDR_W-1:0];
    emit_data  = CODE_BLANK;
    emit_last  = 1'b0;
    d10_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (gate_done) state_next = S_W488;
      end
      S_W488: begin
        if (quo_done) state_next = S_BLANK;
      end
      S_BLANK: begin
        if (out_load) begin
          emit = 1'b1;
          if (cnt == CNT_W'(1)) state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (value == '0) begin
          state_next = S_ZERO;
        end else if (32'(value) > LIMIT) begin
          state_next = S_HELP;
        end else begin
          d10_start  = 1'b1;
          state_next = S_W10;
        end
      end
      S_ZERO: begin
        emit_addr = LSD_ADDR;
        emit_data = CODE_ZERO;
        emit_last = 1'b1;
        if (out_load) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_HELP: begin
        emit_addr = HELP_BASE + cnt[ADDR_W-1:0];
        emit_data = help_code(cnt[1:0]);
        emit_last = cnt == CNT_W'(3);
        if (out_load) begin
          emit = 1'b1;
          if (emit_last) state_next = S_IDLE;
        end
      end
      S_W10: begin
        if (d10_done) state_next = S_DIGIT;
      end
      S_DIGIT: begin
        emit_addr = addr;
        emit_data = digit;
        emit_last = value == '0;
        if (out_load) begin
          emit = 1'b1;
          if (emit_last) begin
            state_next = S_IDLE;
          end else begin
            d10_start  = 1'b1;
            state_next = S_W10;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (disp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_addr <= emit_addr;
      out_data <= emit_data;
      out_last <= emit_last;
    end
    case (state)
      S_W488: begin
        value <= quo;
        cnt   <= NUM_CNT;
      end
      S_BLANK: begin
        if (emit) cnt <= cnt - 1'b1;
      end
      S_CHECK: begin
        cnt  <= '0;
        addr <= LSD_ADDR;
      end
      S_HELP: begin
        if (emit) cnt <= cnt + 1'b1;
      end
      S_W10: begin
        if (d10_done) begin
          value <= d10_quo;
          digit <= d10_rem;
        end
      end
      S_DIGIT: begin
        if (emit) addr <= addr - 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign idle          = state == S_IDLE;
  assign disp.valid    = out_valid;
  assign disp.reg_addr = out_addr;
  assign disp.reg_data = out_data;
  assign disp.last     = out_last;

endmodule

### design/gated_frequency_counter_display_unit.sv
// Gated frequency counter with digit-register display writes.
// A tick that does not close the gate leaves the unit idle and ready for
// the next tick. A tick that closes the gate starts an update. The edge
// total is divided by 488 in a bit-serial divider. NUM_DIGITS blank writes
// follow at one per cycle while the output is not stalled, then a state
// classifies the quotient. After that comes either one zero write, four
// overflow-message writes, or one write per decimal digit. Each digit comes
// from a bit-serial divide by ten. No new tick is accepted during an
// update, and output stalls lengthen it. The final write is held in an
// output register so the next tick can be accepted while it waits. No tick
// is accepted while rst is high. Depends on gfc_pkg, the channel
// interfaces, gfc_accum, gfc_sdiv and gfc_disp.
module gated_frequency_counter_display_unit import gfc_pkg::*; #(
  parameter int NUM_DIGITS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [GATE_W-1:0] cfg_wdata,
  gfc_in_if.sink            tick,
  gfc_out_if.source         disp
);

  gate_t              gate;
  logic               idle;
  logic               tick_fire;
  logic               quo_done;
  logic [TOTAL_W-1:0] quo_full;
  logic [8:0]         quo_rem;

  assign tick.ready = idle && !rst;
  assign tick_fire  = tick.valid && tick.ready;

  gfc_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .fire      (tick_fire),
    .edge_count(tick.edge_count),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .gate      (gate)
  );

  gfc_sdiv #(
    .DIVIDEND_W(TOTAL_W),
    .DIVISOR   (GATE_DIVISOR)
  ) u_div488 (
    .clk      (clk),
    .rst      (rst),
    .start    (gate.done),
    .dividend (gate.total),
    .done     (quo_done),
    .quotient (quo_full),
    .remainder(quo_rem)
  );

  gfc_disp #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_disp (
    .clk      (clk),
    .rst      (rst),
    .gate_done(gate.done),
    .quo_done (quo_done && (quo_rem == quo_rem)),
    .quo      (quo_full[QUO_W-1:0]),
    .idle     (idle),
    .disp     (disp)
  );

endmodule

### dv/gated_frequency_counter_display_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the gated frequency counter display unit.
// Depends on gfc_pkg, the gfc_in_if and gfc_out_if channel interfaces and the top-level RTL.
module gated_frequency_counter_display_unit_tb;
  import gfc_pkg::*;

  localparam int NUM_DIGITS = 6;
  localparam logic [TOTAL_W-1:0] DISP_LIMIT = TOTAL_W'(10 ** NUM_DIGITS - 1);
  localparam int SETTLE_CYCLES = 40;
  localparam int END_CYCLES = 250;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              last;
  } disp_write_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [GATE_W-1:0] cfg_wdata;

  gfc_in_if  tick_if ();
  gfc_out_if disp_if ();

  gated_frequency_counter_display_unit #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .tick     (tick_if),
    .disp     (disp_if)
  );

  // Counter state as the block should hold it.
  logic [TOTAL_W-1:0] sum_edges = '0;
  logic [GATE_W-1:0]  ticks_in_gate = '0;
  logic [GATE_W-1:0]  gate_cfg = GATE_TICKS_RESET;

  disp_write_t pending_writes [$];
  int          errors = 0;
  int          tx_idle_pct = 26;
  int          rx_idle_pct = 47;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Accumulate one tick and queue the display writes of a completed gate.
  function automatic void predict_tick(input logic [EDGE_W-1:0] cnt);
    disp_write_t        run [0:2*NUM_DIGITS-1];
    int                 n;
    int                 slot;
    logic [TOTAL_W-1:0] quot;
    n = 0;
    if (sum_edges > {TOTAL_W{1'b1}} - TOTAL_W'(cnt)) begin
      sum_edges = '1;
    end else begin
      sum_edges = sum_edges + TOTAL_W'(cnt);
    end
    ticks_in_gate = ticks_in_gate + 1'b1;
    if (ticks_in_gate < gate_cfg) return;
    quot = sum_edges / TOTAL_W'(GATE_DIVISOR);
    sum_edges = '0;
    ticks_in_gate = '0;
    for (int r = NUM_DIGITS; r >= 1; r--) begin
      run[n] = '{ADDR_W'(r), CODE_BLANK, 1'b0};
      n++;
    end
    if (quot == 0) begin
      run[n] = '{ADDR_W'(NUM_DIGITS), CODE_ZERO, 1'b0};
      n++;
    end else if (quot > DISP_LIMIT) begin
      run[n]     = '{ADDR_W'(NUM_DIGITS - 3), CODE_H, 1'b0};
      run[n + 1] = '{ADDR_W'(NUM_DIGITS - 2), CODE_E, 1'b0};
      run[n + 2] = '{ADDR_W'(NUM_DIGITS - 1), CODE_L, 1'b0};
      run[n + 3] = '{ADDR_W'(NUM_DIGITS), CODE_P, 1'b0};
      n += 4;
    end else begin
      slot = NUM_DIGITS;
      while (quot != 0) begin
        run[n] = '{ADDR_W'(slot), DATA_W'(quot % 10), 1'b0};
        n++;
        quot = quot / 10;
        slot--;
      end
    end
    run[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_writes.push_back(run[i]);
  endfunction

  // Edge counts spread over all magnitudes, with the full-scale value now and then.
  function automatic logic [EDGE_W-1:0] rand_edge();
    int unsigned bits;
    if ($urandom_range(7, 0) == 0) return '1;
    bits = $urandom_range(EDGE_W, 0);
    return EDGE_W'($urandom & ((32'd1 << bits) - 32'd1));
  endfunction

  initial begin
    disp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      disp_if.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_writes
    disp_write_t want;
    if (!rst && disp_if.valid && disp_if.ready) begin
      if (pending_writes.size() == 0) begin
        $error("display write with none pending: reg_addr %0d reg_data %0h last %0b",
               disp_if.reg_addr, disp_if.reg_data, disp_if.last);
        errors++;
      end else begin
        want = pending_writes.pop_front();
        if (disp_if.reg_addr !== want.addr) begin
          $error("reg_addr: expected %0d, got %0d", want.addr, disp_if.reg_addr);
          errors++;
        end
        if (disp_if.reg_data !== want.data) begin
          $error("reg_data: expected %0h, got %0h", want.data, disp_if.reg_data);
          errors++;
        end
        if (disp_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, disp_if.last);
          errors++;
        end
      end
    end
  end

  // Offers one tick, with a random gap first, and predicts it once the transaction is taken.
  // Valid stays high afterwards so back-to-back ticks need no extra edge.
  task automatic send_tick(input logic [EDGE_W-1:0] cnt);
    if ($urandom_range(99, 0) < tx_idle_pct) begin
      tick_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < tx_idle_pct);
    end
    tick_if.valid      <= 1'b1;
    tick_if.edge_count <= cnt;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    predict_tick(cnt);
  endtask

  task automatic wait_idle();
    tick_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gate(input logic [GATE_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    gate_cfg = val;
  endtask

  // The reset gate is 32 ticks; shortening it below the ticks already seen
  // must close the gate on the very next tick.
  task automatic test_gate_shortened();
    repeat (5) send_tick(rand_edge());
    write_gate(8'd3);
    send_tick(EDGE_W'(488 * 777));
  endtask

  task automatic test_single_tick_gate();
    write_gate(8'd1);
    send_tick('0);
    send_tick(EDGE_W'(487));
    send_tick(EDGE_W'(488));
    send_tick(EDGE_W'(4879));
    send_tick(EDGE_W'(48_800));
    send_tick(EDGE_W'(488 * 4321));
    send_tick('1);
  endtask

  // A gate length of zero behaves like one tick per update.
  task automatic test_zero_gate();
    write_gate(8'd0);
    send_tick(EDGE_W'(488 * 12));
    send_tick(24'h555555);
    send_tick(24'hAAAAAA);
  endtask

  task automatic test_random_gates(input int unsigned n_items, input int unsigned gate_max);
    int unsigned       sent;
    int unsigned       burst;
    logic [GATE_W-1:0] g;
    sent = 0;
    while (sent < n_items) begin
      g = GATE_W'($urandom_range(gate_max, 0));
      write_gate(g);
      burst = $urandom_range(2 * ((g == 0) ? 1 : g), 1);
      repeat (burst) send_tick(rand_edge());
      sent += burst;
    end
  endtask

  // Near full-scale counts over 30 ticks push the quotient past the display range.
  task automatic test_overflow_message();
    write_gate(8'd30);
    repeat (60) send_tick(EDGE_W'($urandom_range(24'hFFFFFF, 16_500_000)));
  endtask

  task automatic test_longest_gate();
    write_gate(8'd255);
    repeat (255) send_tick(EDGE_W'($urandom_range(1 << 20, 0)));
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    tick_if.valid      <= 1'b0;
    tick_if.edge_count <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 26;
    rx_idle_pct = 47;
    test_gate_shortened();
    test_single_tick_gate();
    test_zero_gate();
    test_random_gates(45, 12);

    tx_idle_pct = 47;
    rx_idle_pct = 26;
    test_overflow_message();
    test_random_gates(25, 40);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_longest_gate();

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
